FILE: src/qrc_pkg.sv
// ----------------------------------------------------------------------------
// qrc_pkg: shared constants for the quadrilateral rectangle check
// Register indexes, register widths and reset values, verdict codes.
// ----------------------------------------------------------------------------
`default_nettype none

package qrc_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_EQUAL_TOL = 2'd0;
	localparam cfg_idx_t REG_MAX_SIDE  = 2'd1;
	localparam cfg_idx_t REG_ANGLE_LIM = 2'd2;

	// register widths
	localparam int TOL_W   = 15;
	localparam int SIDE_W  = 15;
	localparam int LIMIT_W = 16;
	localparam int SIDE_SQ_W = 2 * SIDE_W;

	// reset values
	localparam logic [TOL_W-1:0]     TOL_RESET     = 15'd8;
	localparam logic [SIDE_W-1:0]    SIDE_RESET    = 15'd128;
	localparam logic [SIDE_SQ_W-1:0] SIDE_SQ_RESET = 30'd16384;
	localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 16'd7706;

	// verdict codes
	typedef logic [1:0] verdict_t;
	localparam verdict_t VERDICT_OK       = 2'd0;
	localparam verdict_t VERDICT_COINCIDE = 2'd1;
	localparam verdict_t VERDICT_LONG     = 2'd2;
	localparam verdict_t VERDICT_ANGLE    = 2'd3;

endpackage

`default_nettype wire

FILE: src/qrc_angle.sv
// ----------------------------------------------------------------------------
// qrc_angle: right-angle test for one corner
// Decides dot^2 * 2^16 > limit * |u|^2 * |v|^2 over four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module qrc_angle import qrc_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic signed [2*COORD_BITS+1:0] dot,
	input  wire logic [2*COORD_BITS:0]          len_a,
	input  wire logic [2*COORD_BITS:0]          len_b,
	input  wire logic [LIMIT_W-1:0]             limit,
	output logic                                off
);

	localparam int LEN_W  = 2 * COORD_BITS + 1;
	localparam int DOT_W  = 2 * COORD_BITS + 2;
	localparam int DOT2_W = 4 * COORD_BITS + 2;
	localparam int LP_W   = 2 * LEN_W;
	localparam int LO_W   = LP_W / 2;
	localparam int HI_W   = LP_W - LO_W;
	localparam int RHS_W  = LP_W + LIMIT_W;

	logic signed [2*DOT_W-1:0] dsq_full;
	logic [LP_W-1:0]           lp_full;
	logic [LIMIT_W+LO_W-1:0]   plo;
	logic [LIMIT_W+HI_W-1:0]   phi;
	logic [RHS_W-1:0]          rhs;
	logic [RHS_W-1:0]          lhs;

	logic [DOT2_W-1:0]       dot2_s4;
	logic [LP_W-1:0]         lp_s4;
	logic [DOT2_W-1:0]       dot2_s5;
	logic [LIMIT_W+LO_W-1:0] plo_s5;
	logic [LIMIT_W+HI_W-1:0] phi_s5;
	logic [RHS_W-1:0]        lhs_s6;
	logic [RHS_W-1:0]        rhs_s6;
	logic                    off_s7;

	// squares and length product
	always_comb begin
		dsq_full = dot * dot;
		lp_full  = len_a * len_b;
	end

	// limit times the length product, cut in two halves
	always_comb begin
		plo = limit * lp_s4[LO_W-1:0];
		phi = limit * lp_s4[LP_W-1:LO_W];
	end

	// recombine the partial products, scale the dot square
	always_comb begin
		rhs = RHS_W'(plo_s5) + {phi_s5, {LO_W{1'b0}}};
		lhs = {dot2_s5, {LIMIT_W{1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot2_s4 <= dsq_full[DOT2_W-1:0];
			lp_s4   <= lp_full;
			dot2_s5 <= dot2_s4;
			plo_s5  <= plo;
			phi_s5  <= phi;
			lhs_s6  <= lhs;
			rhs_s6  <= rhs;
			off_s7  <= lhs_s6 > rhs_s6;
		end
	end

	assign off = off_s7;

endmodule

`default_nettype wire

FILE: src/quad_rectangle_check.sv
// ----------------------------------------------------------------------------
// quad_rectangle_check: near-rectangle test on four corners
// Checks coincident corners, side lengths and corner angles, gives the
// verdict and the floored corner centroid.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one quadrilateral per beat: corners A, B, C, D in cyclic
//   order as signed fixed-point x/y pairs. m_axis returns one verdict beat
//   per input beat, in order. The cfg port writes tolerance, maximum side
//   and angle limit; write it only while no beat is in flight.
//   Throughput: one beat per cycle while s_axis_tready is high. The depth
//   is set by the angle path: vectors, side products, lengths and dots,
//   dot square and length product, then the limit product split into two
//   halves, recombination, the final compare and the output register.
//   Reset: registers return to defaults (tolerance 8, max side 128, angle
//   limit 7706); the pipeline and output are empty.
//   Stall: the output register plus a one-beat skid hold results while
//   m_axis_tready is low; s_axis_tready drops as soon as the skid
//   fills and the whole pipeline freezes, losing nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_rectangle_check import qrc_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y (lowest bits first)
	input  wire logic [8*COORD_BITS-1:0]   s_axis_tdata,
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	// is_rectangle, verdict, center_x, center_y, zero fill (lowest bits first)
	output logic [((2*COORD_BITS+10)/8)*8-1:0] m_axis_tdata,
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	input  wire logic                      cfg_wr_en,
	input  wire cfg_idx_t                  cfg_index,
	input  wire logic [CFG_DATA_W-1:0]     cfg_data
);

	localparam int C       = COORD_BITS;
	localparam int D_W     = C + 1;
	localparam int PROD_W  = 2 * C + 1;
	localparam int LEN_W   = 2 * C + 1;
	localparam int DOT_W   = 2 * C + 2;
	localparam int SUM_W   = C + 2;
	localparam int FIELD_W = 2 * C + 3;
	localparam int OUT_W   = ((FIELD_W + 7) / 8) * 8;
	localparam int CMP_W   = (LEN_W > SIDE_SQ_W) ? LEN_W : SIDE_SQ_W;
	localparam int MAG_W   = (C > TOL_W) ? C : TOL_W;

	typedef struct packed {
		logic                coin;
		logic                long_side;
		logic signed [C-1:0] cx;
		logic signed [C-1:0] cy;
	} tag_t;

	function automatic logic signed [PROD_W-1:0] smul(
		input logic signed [D_W-1:0] a,
		input logic signed [D_W-1:0] b
	);
		logic signed [2*D_W-1:0] f;
		f = a * b;
		return f[PROD_W-1:0];
	endfunction

	function automatic logic [C-1:0] mag(input logic signed [D_W-1:0] d);
		logic signed [D_W-1:0] n;
		n = d[D_W-1] ? -d : d;
		return n[C-1:0];
	endfunction

	// configuration registers
	logic [TOL_W-1:0]     tol_q;
	logic [SIDE_W-1:0]    max_side_q;
	logic [SIDE_SQ_W-1:0] max_sq_q;
	logic [LIMIT_W-1:0]   limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q      <= TOL_RESET;
			max_side_q <= SIDE_RESET;
			max_sq_q   <= SIDE_SQ_RESET;
			limit_q    <= LIMIT_RESET;
		end else begin
			max_sq_q <= max_side_q * max_side_q;
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_EQUAL_TOL: tol_q      <= cfg_data[TOL_W-1:0];
					REG_MAX_SIDE:  max_side_q <= cfg_data[SIDE_W-1:0];
					REG_ANGLE_LIM: limit_q    <= cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// pipeline control: freeze every pipeline stage while the skid holds a beat
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic sk_valid_q, o_valid_q;

	assign en            = !sk_valid_q;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// stage 1: side and diagonal vectors, partial coordinate sums
	logic signed [C-1:0]   px [4];
	logic signed [C-1:0]   py [4];
	logic signed [D_W-1:0] sdx [4];
	logic signed [D_W-1:0] sdy [4];
	logic signed [D_W-1:0] gdx [2];
	logic signed [D_W-1:0] gdy [2];
	logic signed [D_W-1:0] hx [2];
	logic signed [D_W-1:0] hy [2];

	logic signed [D_W-1:0] sdx_s1 [4];
	logic signed [D_W-1:0] sdy_s1 [4];
	logic signed [D_W-1:0] gdx_s1 [2];
	logic signed [D_W-1:0] gdy_s1 [2];
	logic signed [D_W-1:0] hx_s1 [2];
	logic signed [D_W-1:0] hy_s1 [2];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			px[k] = s_axis_tdata[(2*k)*C +: C];
			py[k] = s_axis_tdata[(2*k+1)*C +: C];
		end
		for (int k = 0; k < 4; k++) begin
			sdx[k] = D_W'(px[k]) - D_W'(px[(k+1)%4]);
			sdy[k] = D_W'(py[k]) - D_W'(py[(k+1)%4]);
		end
		for (int k = 0; k < 2; k++) begin
			gdx[k] = D_W'(px[k]) - D_W'(px[k+2]);
			gdy[k] = D_W'(py[k]) - D_W'(py[k+2]);
			hx[k]  = D_W'(px[2*k]) + D_W'(px[2*k+1]);
			hy[k]  = D_W'(py[2*k]) + D_W'(py[2*k+1]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sdx_s1 <= sdx;
			sdy_s1 <= sdy;
			gdx_s1 <= gdx;
			gdy_s1 <= gdy;
			hx_s1  <= hx;
			hy_s1  <= hy;
		end
	end

	// stage 2: coincidence, side squares, dot terms, centroid
	logic                   coin;
	logic signed [SUM_W-1:0] sum_x, sum_y;
	logic signed [PROD_W-1:0] sqx [4];
	logic signed [PROD_W-1:0] sqy [4];
	logic signed [PROD_W-1:0] tx [4];
	logic signed [PROD_W-1:0] ty [4];

	logic signed [PROD_W-1:0] sqx_s2 [4];
	logic signed [PROD_W-1:0] sqy_s2 [4];
	logic signed [PROD_W-1:0] tx_s2 [4];
	logic signed [PROD_W-1:0] ty_s2 [4];
	tag_t tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7;

	always_comb begin
		coin = 1'b0;
		for (int k = 0; k < 4; k++) begin
			if (MAG_W'(mag(sdx_s1[k])) <= MAG_W'(tol_q) &&
				MAG_W'(mag(sdy_s1[k])) <= MAG_W'(tol_q)) begin
				coin = 1'b1;
			end
		end
		for (int k = 0; k < 2; k++) begin
			if (MAG_W'(mag(gdx_s1[k])) <= MAG_W'(tol_q) &&
				MAG_W'(mag(gdy_s1[k])) <= MAG_W'(tol_q)) begin
				coin = 1'b1;
			end
		end
		for (int k = 0; k < 4; k++) begin
			sqx[k] = smul(sdx_s1[k], sdx_s1[k]);
			sqy[k] = smul(sdy_s1[k], sdy_s1[k]);
			// consecutive sides k and k+1 meet at corner k+1
			tx[k]  = smul(sdx_s1[k], sdx_s1[(k+1)%4]);
			ty[k]  = smul(sdy_s1[k], sdy_s1[(k+1)%4]);
		end
		sum_x = SUM_W'(hx_s1[0]) + SUM_W'(hx_s1[1]);
		sum_y = SUM_W'(hy_s1[0]) + SUM_W'(hy_s1[1]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2           <= sqx;
			sqy_s2           <= sqy;
			tx_s2            <= tx;
			ty_s2            <= ty;
			tag_s2.coin      <= coin;
			tag_s2.long_side <= 1'b0;
			tag_s2.cx        <= sum_x[SUM_W-1:2];
			tag_s2.cy        <= sum_y[SUM_W-1:2];
		end
	end

	// stage 3: squared side lengths and dot products
	logic [LEN_W-1:0]        len_s3 [4];
	logic signed [DOT_W-1:0] dot_s3 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				len_s3[k] <= LEN_W'($unsigned(sqx_s2[k])) + LEN_W'($unsigned(sqy_s2[k]));
				dot_s3[k] <= DOT_W'(tx_s2[k]) + DOT_W'(ty_s2[k]);
			end
			tag_s3 <= tag_s2;
		end
	end

	// stage 4: side length limit; angle lanes run stages 4 to 7
	logic long_side;

	always_comb begin
		long_side = 1'b0;
		for (int k = 0; k < 4; k++) begin
			if (CMP_W'(len_s3[k]) >= CMP_W'(max_sq_q)) begin
				long_side = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s4.coin      <= tag_s3.coin;
			tag_s4.long_side <= long_side;
			tag_s4.cx        <= tag_s3.cx;
			tag_s4.cy        <= tag_s3.cy;
			tag_s5           <= tag_s4;
			tag_s6           <= tag_s5;
			tag_s7           <= tag_s6;
		end
	end

	logic [3:0] off_s7;

	for (genvar g = 0; g < 4; g++) begin : g_angle
		qrc_angle #(
			.COORD_BITS(COORD_BITS)
		) u_angle (
			.clk   (clk),
			.en    (en),
			.dot   (dot_s3[g]),
			.len_a (len_s3[g]),
			.len_b (len_s3[(g+1)%4]),
			.limit (limit_q),
			.off   (off_s7[g])
		);
	end

	// verdict in check order, packed result beat
	verdict_t         verdict;
	logic [OUT_W-1:0] fin;

	always_comb begin
		if (tag_s7.coin) begin
			verdict = VERDICT_COINCIDE;
		end else if (tag_s7.long_side) begin
			verdict = VERDICT_LONG;
		end else if (|off_s7) begin
			verdict = VERDICT_ANGLE;
		end else begin
			verdict = VERDICT_OK;
		end
		fin = OUT_W'({tag_s7.cy, tag_s7.cx, verdict, verdict == VERDICT_OK});
	end

	// output register and one-beat skid
	logic [OUT_W-1:0] o_data_q, sk_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q  <= 1'b0;
			sk_valid_q <= 1'b0;
		end else if (en && v_s7) begin
			if (!o_valid_q || m_axis_tready) begin
				o_valid_q <= 1'b1;
			end else begin
				sk_valid_q <= 1'b1;
			end
		end else if (sk_valid_q && m_axis_tready) begin
			sk_valid_q <= 1'b0;
		end else if (m_axis_tready) begin
			o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s7) begin
			if (!o_valid_q || m_axis_tready) begin
				o_data_q <= fin;
			end else begin
				sk_data_q <= fin;
			end
		end else if (sk_valid_q && m_axis_tready) begin
			o_data_q <= sk_data_q;
		end
	end

	assign m_axis_tvalid = o_valid_q;
	assign m_axis_tdata  = o_data_q;

endmodule

`default_nettype wire

FILE: src/qrc_check.sv
// ----------------------------------------------------------------------------
// qrc_check: port-level checks for quad_rectangle_check
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qrc_check import qrc_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      s_axis_tvalid,
	input wire logic                      s_axis_tready,
	input wire logic [((2*COORD_BITS+10)/8)*8-1:0] m_axis_tdata,
	input wire logic                      m_axis_tvalid,
	input wire logic                      m_axis_tready
);

	localparam int FIELD_W = 2 * COORD_BITS + 3;

	// the accept flag and the verdict code agree
	a_flag_matches_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[2:1] == VERDICT_OK)))
		else $error("is_rectangle disagrees with verdict");

	// fill bits above the fields stay zero
	a_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata >> FIELD_W) == '0))
		else $error("fill bits of result beat not zero");

	// input back-pressure only follows an output stall
	a_ready_after_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without an output stall");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

endmodule

bind quad_rectangle_check qrc_check #(
	.COORD_BITS(COORD_BITS)
) u_qrc_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);

`default_nettype wire
